>>> design/stok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_pkg
// Shared types, token kinds, error codes and character-class helpers for the
// source tokenizer.
// ----------------------------------------------------------------------------
package stok_pkg;

  typedef enum logic [3:0] {
    M_IDLE, M_HASH, M_COMMENT, M_CTILDE, M_LT, M_MINUS, M_MINUSL,
    M_VARST, M_VAR, M_DQ, M_SQ, M_IDENT, M_NUMBER
  } mode_t;

  localparam int KW_DEPTH = 11;
  typedef logic [KW_DEPTH-1:0][7:0] kw_buf_t;

  localparam logic [5:0] K_END         = 6'd0;
  localparam logic [5:0] K_IDENT       = 6'd1;
  localparam logic [5:0] K_NUMBER      = 6'd2;
  localparam logic [5:0] K_VARIABLE    = 6'd3;
  localparam logic [5:0] K_FUNCTION    = 6'd4;
  localparam logic [5:0] K_INT         = 6'd5;
  localparam logic [5:0] K_IF          = 6'd6;
  localparam logic [5:0] K_ELSE        = 6'd7;
  localparam logic [5:0] K_DO          = 6'd8;
  localparam logic [5:0] K_UNTIL       = 6'd9;
  localparam logic [5:0] K_THEN        = 6'd10;
  localparam logic [5:0] K_READ        = 6'd11;
  localparam logic [5:0] K_DISPLAY     = 6'd12;
  localparam logic [5:0] K_DISPLAYLINE = 6'd13;
  localparam logic [5:0] K_RETURN      = 6'd14;
  localparam logic [5:0] K_EQ          = 6'd15;
  localparam logic [5:0] K_NE          = 6'd16;
  localparam logic [5:0] K_LT          = 6'd17;
  localparam logic [5:0] K_LE          = 6'd18;
  localparam logic [5:0] K_GT          = 6'd19;
  localparam logic [5:0] K_GE          = 6'd20;
  localparam logic [5:0] K_COMMA       = 6'd21;
  localparam logic [5:0] K_COLON       = 6'd22;
  localparam logic [5:0] K_SEMI        = 6'd23;
  localparam logic [5:0] K_LPAREN      = 6'd25;
  localparam logic [5:0] K_RPAREN      = 6'd26;
  localparam logic [5:0] K_PLUS        = 6'd27;
  localparam logic [5:0] K_MINUS       = 6'd28;
  localparam logic [5:0] K_SLASH       = 6'd29;
  localparam logic [5:0] K_STAR        = 6'd30;
  localparam logic [5:0] K_PERCENT     = 6'd31;
  localparam logic [5:0] K_LBRACE      = 6'd32;
  localparam logic [5:0] K_RBRACE      = 6'd33;
  localparam logic [5:0] K_ASSIGN      = 6'd34;
  localparam logic [5:0] K_STRING      = 6'd35;
  localparam logic [5:0] K_ARROW       = 6'd36;
  localparam logic [5:0] K_ERROR       = 6'd37;

  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_VAR     = 2'd2;
  localparam logic [1:0] ERR_STRING  = 2'd3;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return is_letter(c) || is_digit(c) || c == "_";
  endfunction

  function automatic logic [5:0] punct_kind(input logic [7:0] c);
    logic [5:0] k;
    case (c)
      ",":     k = K_COMMA;
      ":":     k = K_COLON;
      ";":     k = K_SEMI;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "+":     k = K_PLUS;
      "/":     k = K_SLASH;
      "*":     k = K_STAR;
      "%":     k = K_PERCENT;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      "=":     k = K_ASSIGN;
      default: k = K_END;
    endcase
    return k;
  endfunction

  function automatic logic [5:0] op_kind(input logic [7:0] a, input logic [7:0] b);
    logic [5:0] k;
    k = K_END;
    if (a == "e" && b == "q") k = K_EQ;
    else if (a == "n" && b == "e") k = K_NE;
    else if (a == "l" && b == "t") k = K_LT;
    else if (a == "l" && b == "e") k = K_LE;
    else if (a == "g" && b == "t") k = K_GT;
    else if (a == "g" && b == "e") k = K_GE;
    return k;
  endfunction

  // Keyword lookup; only the first n bytes of the buffer are compared.
  function automatic logic [5:0] kw_kind(input kw_buf_t b, input logic [3:0] n);
    logic [87:0] s;
    logic [5:0]  k;
    s = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9], b[10]};
    k = K_IDENT;
    case (n)
      4'd2: begin
        if (s[87 -: 16] == "if") k = K_IF;
        else if (s[87 -: 16] == "do") k = K_DO;
      end
      4'd3: if (s[87 -: 24] == "int") k = K_INT;
      4'd4: begin
        if (s[87 -: 32] == "else") k = K_ELSE;
        else if (s[87 -: 32] == "then") k = K_THEN;
        else if (s[87 -: 32] == "read") k = K_READ;
      end
      4'd5: if (s[87 -: 40] == "until") k = K_UNTIL;
      4'd6: if (s[87 -: 48] == "return") k = K_RETURN;
      4'd7: if (s[87 -: 56] == "display") k = K_DISPLAY;
      4'd8: if (s[87 -: 64] == "function") k = K_FUNCTION;
      4'd11: if (s == "displayline") k = K_DISPLAYLINE;
      default: k = K_IDENT;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

>>> design/stok_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and the per-byte scan logic; yields up to three tokens per
// accepted beat.
// ----------------------------------------------------------------------------
module stok_scan #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16,
  localparam int RW = 8 + POSITION_BITS + LENGTH_BITS
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              beat,
  input  wire logic [7:0]        in_byte,
  input  wire logic              in_end,
  output logic [1:0]             res_count,
  output logic [2:0][RW:0]       res
);

  localparam logic [LENGTH_BITS-1:0] LMAX = {LENGTH_BITS{1'b1}};
  localparam logic [LENGTH_BITS-1:0] LKW  = LENGTH_BITS'(stok_pkg::KW_DEPTH);

  stok_pkg::mode_t            mode, mode_next;
  logic [POSITION_BITS-1:0]   pos, pos_next;
  logic [POSITION_BITS-1:0]   tstart, tstart_next;
  logic [LENGTH_BITS-1:0]     tlen, tlen_next;
  stok_pkg::kw_buf_t          kw, kw_next;
  logic [7:0]                 la, la_next;

  function automatic logic [RW:0] mk(input logic [5:0] k, input logic [POSITION_BITS-1:0] s,
                                     input logic [LENGTH_BITS-1:0] l, input logic [1:0] e);
    return {1'b0, e, l, s, k};
  endfunction

  always_comb begin
    logic        go;
    logic [5:0]  k;
    logic [1:0]  cnt;
    mode_next   = mode;
    tstart_next = tstart;
    tlen_next   = tlen;
    kw_next     = kw;
    la_next     = la;
    pos_next    = pos;
    res         = '0;
    cnt         = 2'd0;
    go          = 1'b0;
    k           = stok_pkg::K_END;
    if (in_end) begin
      unique case (mode)
        stok_pkg::M_COMMENT, stok_pkg::M_CTILDE: begin
          res[cnt] = mk(stok_pkg::K_ERROR, tstart, tlen, stok_pkg::ERR_COMMENT);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_MINUS: begin
          res[cnt] = mk(stok_pkg::K_MINUS, tstart, LENGTH_BITS'(1), stok_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_MINUSL: begin
          res[0] = mk(stok_pkg::K_MINUS, tstart, LENGTH_BITS'(1), stok_pkg::ERR_NONE);
          res[1] = mk(stok_pkg::K_IDENT, tstart + 1'b1, LENGTH_BITS'(1), stok_pkg::ERR_NONE);
          cnt = 2'd2;
        end
        stok_pkg::M_VARST: begin
          res[cnt] = mk(stok_pkg::K_ERROR, tstart, LENGTH_BITS'(1), stok_pkg::ERR_VAR);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_VAR: begin
          res[cnt] = mk(stok_pkg::K_VARIABLE, tstart, tlen, stok_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_DQ, stok_pkg::M_SQ: begin
          res[cnt] = mk(stok_pkg::K_ERROR, tstart, tlen, stok_pkg::ERR_STRING);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_IDENT: begin
          k = (tlen > LKW) ? stok_pkg::K_IDENT : stok_pkg::kw_kind(kw, tlen[3:0]);
          res[cnt] = mk(k, tstart, tlen, stok_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end
        stok_pkg::M_NUMBER: begin
          res[cnt] = mk(stok_pkg::K_NUMBER, tstart, tlen, stok_pkg::ERR_NONE);
          cnt = cnt + 2'd1;
        end
        default: ;
      endcase
      res[cnt] = mk(stok_pkg::K_END, pos, '0, stok_pkg::ERR_NONE);
      cnt = cnt + 2'd1;
      mode_next   = stok_pkg::M_IDLE;
      pos_next    = '0;
      tstart_next = '0;
      tlen_next   = '0;
    end else if (in_byte != 8'h0d) begin
      pos_next = pos + 1'b1;
      go = 1'b1;
    end
    // A byte may end the pending token and then be rescanned: at most three passes.
    for (int it = 0; it < 3; it++) begin
      if (go) begin
        go = 1'b0;
        unique case (mode_next)
          stok_pkg::M_IDLE: begin
            if (!(in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0a)) begin
              tstart_next = pos;
              tlen_next   = LENGTH_BITS'(1);
              if (in_byte == "#") mode_next = stok_pkg::M_HASH;
              else if (in_byte == "<") mode_next = stok_pkg::M_LT;
              else if (in_byte == "-") mode_next = stok_pkg::M_MINUS;
              else if (in_byte == "$") mode_next = stok_pkg::M_VARST;
              else if (in_byte == 8'h22 || in_byte == 8'h27) begin
                mode_next   = (in_byte == 8'h22) ? stok_pkg::M_DQ : stok_pkg::M_SQ;
                tstart_next = pos + 1'b1;
                tlen_next   = '0;
              end else if (stok_pkg::is_letter(in_byte) || in_byte == "_") begin
                mode_next  = stok_pkg::M_IDENT;
                kw_next[0] = in_byte;
              end else if (stok_pkg::is_digit(in_byte)) begin
                mode_next = stok_pkg::M_NUMBER;
              end else if (stok_pkg::punct_kind(in_byte) != stok_pkg::K_END) begin
                res[cnt] = mk(stok_pkg::punct_kind(in_byte), pos, LENGTH_BITS'(1),
                              stok_pkg::ERR_NONE);
                cnt = cnt + 2'd1;
              end
            end
          end
          stok_pkg::M_HASH: begin
            mode_next = stok_pkg::M_IDLE;
            if (in_byte == "~") begin
              mode_next = stok_pkg::M_COMMENT;
              if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            end else go = 1'b1;
          end
          stok_pkg::M_COMMENT: begin
            if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            if (in_byte == "~") mode_next = stok_pkg::M_CTILDE;
          end
          stok_pkg::M_CTILDE: begin
            if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            if (in_byte == "#") mode_next = stok_pkg::M_IDLE;
            else if (in_byte != "~") mode_next = stok_pkg::M_COMMENT;
          end
          stok_pkg::M_LT: begin
            mode_next = stok_pkg::M_IDLE;
            if (in_byte == "-") begin
              res[cnt] = mk(stok_pkg::K_ARROW, tstart_next, LENGTH_BITS'(2), stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
            end else go = 1'b1;
          end
          stok_pkg::M_MINUS: begin
            if (in_byte == "e" || in_byte == "n" || in_byte == "l" || in_byte == "g") begin
              la_next   = in_byte;
              mode_next = stok_pkg::M_MINUSL;
            end else begin
              res[cnt] = mk(stok_pkg::K_MINUS, tstart_next, LENGTH_BITS'(1), stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
              go = 1'b1;
            end
          end
          stok_pkg::M_MINUSL: begin
            k = stok_pkg::op_kind(la_next, in_byte);
            if (k != stok_pkg::K_END) begin
              res[cnt] = mk(k, tstart_next + 1'b1, LENGTH_BITS'(2), stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
            end else begin
              // no operator: the minus stands alone and its letter opens an identifier
              res[cnt] = mk(stok_pkg::K_MINUS, tstart_next, LENGTH_BITS'(1), stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              tstart_next = tstart_next + 1'b1;
              tlen_next   = LENGTH_BITS'(1);
              kw_next[0]  = la_next;
              mode_next   = stok_pkg::M_IDENT;
              go = 1'b1;
            end
          end
          stok_pkg::M_VARST: begin
            if (stok_pkg::is_letter(in_byte) || in_byte == "_") begin
              mode_next   = stok_pkg::M_VAR;
              tstart_next = pos;
              tlen_next   = LENGTH_BITS'(1);
            end else begin
              res[cnt] = mk(stok_pkg::K_ERROR, tstart_next, LENGTH_BITS'(1), stok_pkg::ERR_VAR);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
              go = 1'b1;
            end
          end
          stok_pkg::M_VAR: begin
            if (stok_pkg::is_word(in_byte)) begin
              if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            end else begin
              res[cnt] = mk(stok_pkg::K_VARIABLE, tstart_next, tlen_next, stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
              go = 1'b1;
            end
          end
          stok_pkg::M_DQ, stok_pkg::M_SQ: begin
            if (in_byte == ((mode_next == stok_pkg::M_DQ) ? 8'h22 : 8'h27)) begin
              res[cnt] = mk(stok_pkg::K_STRING, tstart_next, tlen_next, stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
            end else if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
          end
          stok_pkg::M_IDENT: begin
            if (stok_pkg::is_word(in_byte)) begin
              if (tlen_next < LKW) kw_next[tlen_next[3:0]] = in_byte;
              if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            end else begin
              k = (tlen_next > LKW) ? stok_pkg::K_IDENT
                                    : stok_pkg::kw_kind(kw_next, tlen_next[3:0]);
              res[cnt] = mk(k, tstart_next, tlen_next, stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
              go = 1'b1;
            end
          end
          stok_pkg::M_NUMBER: begin
            if (stok_pkg::is_digit(in_byte)) begin
              if (tlen_next != LMAX) tlen_next = tlen_next + 1'b1;
            end else begin
              res[cnt] = mk(stok_pkg::K_NUMBER, tstart_next, tlen_next, stok_pkg::ERR_NONE);
              cnt = cnt + 2'd1;
              mode_next = stok_pkg::M_IDLE;
              go = 1'b1;
            end
          end
          default: begin
            mode_next = stok_pkg::M_IDLE;
            go = 1'b1;
          end
        endcase
      end
    end
    if (cnt != 2'd0) res[cnt - 2'd1][RW] = 1'b1;
    res_count = cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= stok_pkg::M_IDLE;
      pos    <= '0;
      tstart <= '0;
      tlen   <= '0;
    end else if (beat) begin
      mode   <= mode_next;
      pos    <= pos_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      kw <= kw_next;
      la <= la_next;
    end
  end

endmodule
`default_nettype wire

>>> design/stok_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stok_fifo
// Four-entry token queue; takes up to three tokens a cycle, gives at most one.
// ----------------------------------------------------------------------------
module stok_fifo #(
  parameter int W = 57
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [1:0]     push_n,
  input  wire logic [2:0][W-1:0] din,
  input  wire logic           pop,
  output logic [W-1:0]        dout,
  output logic                not_empty,
  output logic                room
);

  logic [3:0][W-1:0] mem;
  logic [1:0]        wp, rp;
  logic [2:0]        count, count_next;

  assign count_next = count + 3'(push_n) - 3'(pop);
  assign dout       = mem[rp];
  assign not_empty  = count != 3'd0;
  assign room       = count <= 3'd1;   // worst case beat brings three tokens

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_n) mem[wp + 2'(i)] <= din[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      wp    <= wp + push_n;
      rp    <= rp + 2'(pop);
      count <= count_next;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst) count <= 3'd4)
    else $error("token queue overflow");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != 3'd0)
    else $error("pop from empty token queue");
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd0 |-> (count - 3'(pop) + 3'(push_n)) <= 3'd4)
    else $error("push beyond queue room");

endmodule
`default_nettype wire

>>> design/source_tokenizer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// source_tokenizer_top
// Streaming tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle and scanned in the same cycle; each byte
// yields zero to three tokens, which enter a four-entry output queue and leave
// one per cycle while the sink is ready, none before the cycle after the
// byte's beat. The input stalls only while the queue holds two or more tokens,
// so with a ready sink a byte that yields two or three tokens holds the input
// until the queue is down to one token, and streams of at most one token per
// byte run at one beat per clock. A beat with tuser set carries no byte: it
// flushes the pending token, emits the end token and returns the scanner to
// its reset state. Carriage returns are skipped and do not advance the offset.
module source_tokenizer_top #(
  parameter int POSITION_BITS = 32,
  parameter int LENGTH_BITS   = 16,
  localparam int RW = 8 + POSITION_BITS + LENGTH_BITS,
  localparam int OW = ((RW + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  input  wire logic [7:0]    s_tdata,   // source_byte
  input  wire logic          s_tuser,   // end_of_source
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output logic [OW-1:0]      m_tdata,   // token_kind, lexeme_start, lexeme_length, error_code
  output logic               m_tlast    // last_result
);

  logic              beat;
  logic [1:0]        res_count;
  logic [2:0][RW:0]  res;
  logic [RW:0]       head;

  assign beat = s_tvalid && s_tready;

  stok_scan #(.POSITION_BITS(POSITION_BITS), .LENGTH_BITS(LENGTH_BITS)) u_scan (
    .clk(clk), .rst(rst), .beat(beat), .in_byte(s_tdata), .in_end(s_tuser),
    .res_count(res_count), .res(res)
  );

  stok_fifo #(.W(RW + 1)) u_fifo (
    .clk(clk), .rst(rst), .push_n(beat ? res_count : 2'd0), .din(res),
    .pop(m_tvalid && m_tready), .dout(head), .not_empty(m_tvalid), .room(s_tready)
  );

  assign m_tdata = OW'(head[RW-1:0]);
  assign m_tlast = head[RW];

endmodule
`default_nettype wire
